>>> hdl/rhh_pkg.sv
// shared codes and fixed field widths for the robin hood hash table
`default_nettype none
package rhh_pkg;
    localparam int KEY_BITS       = 64;
    localparam int VALUE_IN_BITS  = 32;
    localparam int SLOT_OUT_BITS  = 8;
    localparam int COUNT_OUT_BITS = 9;
    localparam int CFG_BITS       = 9;
    localparam logic [CFG_BITS-1:0] MAX_RESET = 9'd217;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_REPLACE = 3'd1;
    localparam logic [2:0] OP_FIND    = 3'd2;
    localparam logic [2:0] OP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_PRESENT   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_KEY   = 3'd4;
endpackage
`default_nettype wire

>>> hdl/rhh_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/robin_hood_hash_table.sv
// robin hood key/value table with backward-shift delete, one slot ram
//
//  channel   signals                                   transfer when
//  command   i_start, o_busy, i_op, i_key, i_value     i_start && !o_busy
//  result    o_done, o_status, o_slot_index, ...       o_done (one cycle)
//  config    i_cfg_we, i_cfg_data                      i_cfg_we
//
// clear, bad key and unknown ops answer in the cycle after the transfer; a lookup
// probes one slot per cycle from the home slot (set by the ram read port); a remove
// then alternates a read state and a check state per entry shifted back, and an
// insert or replace of a new key then walks its placement run from the home slot.
// for ops that go busy, the result strobe comes in the first cycle that busy is low.
// synchronous active-low reset empties the table; the receiver cannot stall.
`default_nettype none
module robin_hood_hash_table
    import rhh_pkg::*;
#(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic [2:0]                i_op,
    input  wire logic [KEY_BITS-1:0]       i_key,
    input  wire logic [VALUE_IN_BITS-1:0]  i_value,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_BITS-1:0]       i_cfg_data,
    output logic                           o_done,
    output logic [2:0]                     o_status,
    output logic [SLOT_OUT_BITS-1:0]       o_slot_index,
    output logic [VALUE_IN_BITS-1:0]       o_found_value,
    output logic [COUNT_OUT_BITS-1:0]      o_entry_count
);
    localparam int AW = $clog2(SLOTS);
    localparam int VW = (VALUE_BITS < VALUE_IN_BITS) ? VALUE_BITS : VALUE_IN_BITS;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int RW = AW + KEY_BITS + VW;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LK   = 3'd1;
    localparam logic [2:0] S_PL   = 3'd2;
    localparam logic [2:0] S_SBR  = 3'd3;
    localparam logic [2:0] S_SBC  = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [2:0]               r_op, n_op;
    logic [KEY_BITS-1:0]      r_key, n_key;
    logic [VW-1:0]            r_val, n_val;
    logic [AW-1:0]            r_idx, n_idx;
    logic [AW-1:0]            r_dist, n_dist;
    logic [AW-1:0]            r_cd, n_cd;
    logic [KEY_BITS-1:0]      r_ck, n_ck;
    logic [VW-1:0]            r_cv, n_cv;
    logic                     r_landed, n_landed;
    logic [AW-1:0]            r_first, n_first;
    logic [AW-1:0]            r_where, n_where;
    logic [SLOTS-1:0]         r_used, n_used;
    logic [CW-1:0]            r_count, n_count;
    logic [CFG_BITS-1:0]      r_max;
    logic                     r_done, n_done;
    logic [2:0]               r_status, n_status;
    logic [AW-1:0]            r_slot, n_slot;
    logic [VW-1:0]            r_fval, n_fval;
    logic [COUNT_OUT_BITS-1:0] r_ecount;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [RW-1:0] wdata, q;
    logic [AW-1:0] q_dist, nx;
    logic [KEY_BITS-1:0] q_key;
    logic [VW-1:0] q_val;
    logic          emit;

    assign q_dist = q[RW-1 -: AW];
    assign q_key  = q[KEY_BITS+VW-1 -: KEY_BITS];
    assign q_val  = q[VW-1:0];
    assign nx     = r_idx + 1'b1;

    rhh_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(q)
    );

    always_comb begin
        n_state = r_state; n_op = r_op; n_key = r_key; n_val = r_val;
        n_idx = r_idx; n_dist = r_dist; n_cd = r_cd; n_ck = r_ck; n_cv = r_cv;
        n_landed = r_landed; n_first = r_first; n_where = r_where;
        n_used = r_used; n_count = r_count;
        n_done = 1'b0; n_status = r_status; n_slot = r_slot; n_fval = r_fval;
        emit = 1'b0;
        we = 1'b0; waddr = r_idx; wdata = {r_cd, r_ck, r_cv};
        raddr = nx;
        case (r_state)
            S_IDLE: begin
                raddr = AW'(i_key);
                if (i_start) begin
                    n_op  = i_op;
                    n_key = i_key;
                    n_val = i_value[VW-1:0];
                    n_idx = AW'(i_key);
                    n_dist = '0;
                    n_slot = '0; n_fval = '0; n_status = ST_OK;
                    if (i_op == OP_CLEAR) begin
                        n_used = '0; n_count = '0; emit = 1'b1;
                    end else if (i_op > OP_CLEAR) begin
                        n_status = ST_NOT_FOUND; emit = 1'b1;
                    end else if (i_key == '0) begin
                        n_status = ST_BAD_KEY; emit = 1'b1;
                    end else begin
                        n_state = S_LK;
                    end
                end
            end
            S_LK: begin
                if (!r_used[r_idx] || r_dist > q_dist) begin
                    if (r_op == OP_INSERT || r_op == OP_REPLACE) begin
                        if (MW'(r_count) >= MW'(r_max) || MW'(r_count) >= MW'(SLOTS)) begin
                            n_status = ST_FULL; emit = 1'b1;
                        end else begin
                            // restart from home carrying the new entry
                            raddr = AW'(r_key);
                            n_idx = AW'(r_key);
                            n_cd = '0; n_ck = r_key; n_cv = r_val;
                            n_landed = 1'b0;
                            n_state = S_PL;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND; emit = 1'b1;
                    end
                end else if (q_key == r_key) begin
                    n_slot = r_idx;
                    case (r_op)
                        OP_FIND: begin
                            n_fval = q_val; emit = 1'b1;
                        end
                        OP_REMOVE: begin
                            n_where = r_idx; n_dist = '0; n_state = S_SBR;
                        end
                        OP_REPLACE: begin
                            we = 1'b1; wdata = {q_dist, q_key, r_val};
                            n_fval = r_val; emit = 1'b1;
                        end
                        default: begin
                            n_status = ST_PRESENT; n_fval = q_val; emit = 1'b1;
                        end
                    endcase
                end else if (r_dist == LAST) begin
                    // every slot holds another key, so a new key finds the table full
                    if (r_op == OP_INSERT || r_op == OP_REPLACE) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                    emit = 1'b1;
                end else begin
                    n_idx = nx; n_dist = r_dist + 1'b1;
                end
            end
            S_PL: begin
                if (!r_used[r_idx]) begin
                    we = 1'b1;
                    n_used[r_idx] = 1'b1;
                    n_count = r_count + 1'b1;
                    n_slot = r_landed ? r_first : r_idx;
                    emit = 1'b1;
                end else begin
                    if (r_cd > q_dist) begin
                        // swap with the richer resident
                        we = 1'b1;
                        n_ck = q_key; n_cv = q_val; n_cd = q_dist + 1'b1;
                        if (!r_landed) begin
                            n_landed = 1'b1; n_first = r_idx;
                        end
                    end else begin
                        n_cd = r_cd + 1'b1;
                    end
                    n_idx = nx;
                end
            end
            S_SBR: begin
                n_state = S_SBC;
            end
            S_SBC: begin
                if (!r_used[nx] || q_dist == '0) begin
                    n_used[r_idx] = 1'b0;
                    emit = 1'b1;
                end else begin
                    we = 1'b1;
                    wdata = {q_dist - 1'b1, q_key, q_val};
                    if (r_dist == LAST) begin
                        n_used[nx] = 1'b0;
                        emit = 1'b1;
                    end else begin
                        n_idx = nx; n_dist = r_dist + 1'b1; n_state = S_SBR;
                    end
                end
                if (emit && r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
                n_slot = r_where;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (emit) begin
            n_done = 1'b1;
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_count <= '0;
            r_max   <= MAX_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
        end
        r_op <= n_op; r_key <= n_key; r_val <= n_val;
        r_idx <= n_idx; r_dist <= n_dist; r_cd <= n_cd; r_ck <= n_ck; r_cv <= n_cv;
        r_landed <= n_landed; r_first <= n_first; r_where <= n_where;
        r_status <= n_status; r_slot <= n_slot; r_fval <= n_fval;
        r_ecount <= COUNT_OUT_BITS'(n_count);
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_slot_index  = SLOT_OUT_BITS'(r_slot);
    assign o_found_value = VALUE_IN_BITS'(r_fval);
    assign o_entry_count = r_ecount;
endmodule
`default_nettype wire

>>> hdl/rhh_checker.sv
// port-level checks for the robin hood hash table, bound to the top level
`default_nettype none
module rhh_checker
    import rhh_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_start,
    input wire logic                      o_busy,
    input wire logic                      o_done,
    input wire logic [2:0]                o_status,
    input wire logic [SLOT_OUT_BITS-1:0]  o_slot_index,
    input wire logic [VALUE_IN_BITS-1:0]  o_found_value
);
    // every accepted command either answers at once or keeps the block busy
    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted command neither busy nor answered");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result shown while still busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_NOT_FOUND || o_status == ST_FULL
                    || o_status == ST_BAD_KEY))
        |-> (o_slot_index == '0 && o_found_value == '0))
        else $error("failed operation reports a slot or value");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !(i_start && !o_busy)) |=> !o_done)
        else $error("result strobe without a command");
endmodule

bind robin_hood_hash_table rhh_checker u_rhh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_slot_index (o_slot_index),
    .o_found_value(o_found_value)
);
`default_nettype wire
